// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;
	// radicand saturated to 16 bits: its root then never passes 255
	localparam int SQ_W = 16;
	localparam int ROOT_STEPS = 8;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic shift;      // take the fetched column into the window
		logic start;      // latch masked window, start filter
		logic root_step;  // one root iteration
	} sem_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/sem_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sem_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
	modport sink (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface sem_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       frame_last;
	modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
	modport sink (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sobel 3x3 edge magnitude on an RGB raster stream.
// Input channel in_ch: one word per pixel (req_type 0) or flush tick (req_type 1).
// Output channel out_ch: per-channel magnitude clamped to 255, frame_last on the
// final pixel of the frame. Results lag the input by one row plus one column;
// after the last pixel send frame_width + 1 flush words to drain the frame.
// Flush words arriving while pixels are still due are consumed and dropped.
// Each item passes through accept, store read and window shift, then, when it yields a
// result, through the filter and the 8-step square root, and it waits while the receiver
// holds ready low.
// One item at a time: ready is high only in the idle state; a stalled result
// holds steady in the output register.
// Configuration: cfg_we/cfg_idx/cfg_data, index 0 frame_width, 1 frame_height;
// write only when idle. Reset: 640x480, position counters at zero; line-store
// contents are undefined but only ever feed masked border taps.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	sem_in_if.sink                              in_ch,
	sem_out_if.source                           out_ch
);
	import sem_pkg::*;

	sem_cmd_t cmd;
	pixel_t top_px, mid_px, new_px, mag;
	logic [3:0] edge_mask;

	sem_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_ch, .out_ch,
		.cmd, .top_px, .mid_px, .new_px, .edge_mask, .mag
	);

	sem_datapath u_dp (
		.clk, .cmd, .top_px, .mid_px, .new_px, .edge_mask, .mag
	);
endmodule
`default_nettype wire

// ===== rtl/sem_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sem_datapath (
	input  wire logic              clk,
	input  wire sem_pkg::sem_cmd_t cmd,
	input  wire sem_pkg::pixel_t   top_px,
	input  wire sem_pkg::pixel_t   mid_px,
	input  wire sem_pkg::pixel_t   new_px,
	input  wire logic [3:0]        edge_mask,   // top, bottom, left, right
	output sem_pkg::pixel_t        mag
);
	import sem_pkg::*;

	pixel_t win_q [3][3];
	logic signed [11:0] gx_q [3];
	logic signed [11:0] gy_q [3];
	logic [SQ_W-1:0] rem_q [3];
	logic [SQ_W-1:0] root_q [3];
	logic [SQ_W-1:0] bit_q;

	function automatic logic [7:0] chan(input pixel_t p, input int k);
		return p[8*k +: 8];
	endfunction

	// window shift
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= top_px;
			win_q[1][2] <= mid_px;
			win_q[2][2] <= new_px;
		end
	end

	// masked kernels, then gx^2+gy^2 saturated to 16 bits, then an iterative
	// digit-by-digit root
	always_ff @(posedge clk) begin
		pixel_t m [3][3];
		logic signed [11:0] v [3][3];
		logic signed [11:0] gx, gy;
		logic signed [23:0] sqx, sqy;
		logic [24:0] sum_sq;
		logic [SQ_W:0] trial;
		if (cmd.start) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					m[i][j] = ((i == 0 && edge_mask[3]) || (i == 2 && edge_mask[2]) ||
						(j == 0 && edge_mask[1]) || (j == 2 && edge_mask[0]))
						? '0 : win_q[i][j];
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						v[i][j] = 12'(signed'({4'd0, chan(m[i][j], k)}));
				gx = (v[0][2] - v[0][0]) + 12'sd2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
				gy = (v[2][0] - v[0][0]) + 12'sd2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
				gx_q[k] <= gx;
				gy_q[k] <= gy;
				rem_q[k] <= '0;
				root_q[k] <= '0;
			end
			bit_q <= '0;
		end else if (cmd.root_step) begin
			if (bit_q == '0) begin
				for (int k = 0; k < 3; k++) begin
					sqx = gx_q[k] * gx_q[k];
					sqy = gy_q[k] * gy_q[k];
					sum_sq = {1'b0, sqx} + {1'b0, sqy};
					rem_q[k] <= (sum_sq[24:SQ_W] != '0) ? '1 : sum_sq[SQ_W-1:0];
				end
				bit_q <= SQ_W'(1) << (SQ_W - 2);
			end else begin
				for (int k = 0; k < 3; k++) begin
					trial = {1'b0, rem_q[k]} - ({1'b0, root_q[k]} + {1'b0, bit_q});
					if (!trial[SQ_W]) begin
						rem_q[k] <= trial[SQ_W-1:0];
						root_q[k] <= (root_q[k] >> 1) + bit_q;
					end else begin
						root_q[k] <= root_q[k] >> 1;
					end
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			mag[8*k +: 8] = root_q[k][7:0];
	end
endmodule
`default_nettype wire

// ===== rtl/sem_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sem_ctrl #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	sem_in_if.sink                             in_ch,
	sem_out_if.source                          out_ch,
	output sem_pkg::sem_cmd_t                  cmd,
	output sem_pkg::pixel_t                    top_px,
	output sem_pkg::pixel_t                    mid_px,
	output sem_pkg::pixel_t                    new_px,
	output logic [3:0]                         edge_mask,
	input  wire sem_pkg::pixel_t               mag
);
	import sem_pkg::*;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT, S_FILT, S_ROOT, S_OUT} state_t;
	state_t state_q;

	logic [10:0] fw_q;
	logic [12:0] fh_q;
	logic [CW-1:0] in_col_q, out_col_q, w;
	logic [13:0] in_row_q, out_row_q;
	logic [12:0] h;
	logic [3:0] cnt_q;
	logic emit_q, last_c;
	logic [AW-1:0] addr_q;
	pixel_t mem_a [MAX_WIDTH];
	pixel_t mem_b [MAX_WIDTH];
	pixel_t rd_a_q, rd_b_q, new_q;
	result_t res_q;
	sem_cmd_t cmd_d;

	always_comb begin
		if (fw_q == '0) w = CW'(1);
		else if ({21'd0, fw_q} > MAX_WIDTH) w = CW'(MAX_WIDTH);
		else w = CW'(fw_q);
		h = (fh_q == '0) ? 13'd1 : fh_q;
	end

	// commands are registered: each reaches the datapath in the cycle after the state that calls for it
	always_comb begin
		cmd_d = '0;
		cmd_d.shift = (state_q == S_SHIFT);
		cmd_d.start = (state_q == S_FILT);
		cmd_d.root_step = (state_q == S_ROOT) && (cnt_q <= 4'(ROOT_STEPS));
	end

	assign last_c = (out_row_q + 14'd1 >= {1'b0, h}) && ((out_col_q + CW'(1)) >= w);
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.out_red = res_q.red;
	assign out_ch.out_green = res_q.green;
	assign out_ch.out_blue = res_q.blue;
	assign out_ch.frame_last = res_q.last;
	assign top_px = rd_b_q;
	assign mid_px = rd_a_q;
	assign new_px = new_q;
	assign edge_mask = {out_row_q == '0, out_row_q + 14'd1 >= {1'b0, h},
		out_col_q == '0, (out_col_q + CW'(1)) >= w};

	// line stores: read then write same column
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_a_q <= mem_a[addr_q];
			rd_b_q <= mem_b[addr_q];
		end
		if (state_q == S_SHIFT) begin
			mem_a[addr_q] <= new_q;
			mem_b[addr_q] <= rd_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fw_q <= 11'd640;
			fh_q <= 13'd480;
			in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
			cmd <= '0;
			cnt_q <= '0;
			emit_q <= 1'b0;
		end else begin
			cmd <= cmd_d;
			if (cfg_we) begin
				if (cfg_idx == REG_FRAME_WIDTH) fw_q <= cfg_data[10:0];
				else if (cfg_idx == REG_FRAME_HEIGHT) fh_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (in_row_q < {1'b0, h} && in_ch.req_type == REQ_FLUSH) begin
							state_q <= S_IDLE;
						end else begin
							new_q <= (in_row_q < {1'b0, h})
								? {in_ch.in_red, in_ch.in_green, in_ch.in_blue} : '0;
							addr_q <= AW'((in_col_q < w) ? in_col_q : w - CW'(1));
							emit_q <= (in_row_q >= 14'd2) || (in_row_q == 14'd1 && in_col_q != '0);
							if (in_col_q + CW'(1) >= w) begin
								in_col_q <= '0;
								in_row_q <= in_row_q + 14'd1;
							end else in_col_q <= in_col_q + CW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_SHIFT;
				S_SHIFT: begin
					state_q <= emit_q ? S_FILT : S_IDLE;
				end
				S_FILT: begin
					cnt_q <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					// start, one load and ROOT_STEPS iterations, then the root is settled
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(ROOT_STEPS + 2)) begin
						state_q <= S_OUT;
						res_q <= '{red: mag[23:16], green: mag[15:8], blue: mag[7:0], last: last_c};
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
						if (res_q.last) begin
							in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
						end else if (out_col_q + CW'(1) >= w) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 14'd1;
						end else out_col_q <= out_col_q + CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> $stable(res_q)) else $error("result changed");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("command clash");
`endif
endmodule
`default_nettype wire
